// ----- rtl/inverse_variance_meta_pool_core_macros.svh -----
// Assertion macros for the pooling core.
`ifndef INVERSE_VARIANCE_META_POOL_CORE_MACROS_SVH
`define INVERSE_VARIANCE_META_POOL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IVMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IVMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IVMP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IVMP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ivmp_pkg.sv -----
package ivmp_pkg;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVW  = 7'b0000010,
    ST_DIVT  = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_FIN   = 7'b0010000,
    ST_ROOT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    DSEL_W    = 3'd0,
    DSEL_T    = 3'd1,
    DSEL_PEFF = 3'd2,
    DSEL_PVAR = 3'd3,
    DSEL_Z    = 3'd4
  } dsel_t;

  typedef struct packed {
    logic  load;
    logic  div_start;
    dsel_t div_sel;
    logic  acc;
    logic  sq_start;
    logic  out_load;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sq_done;
    logic vzero;
    logic wzero;
    logic last;
  } sts_t;

  localparam int NumBits = 192;
  localparam int CntW = 8;

endpackage

// ----- rtl/ivmp_if.sv -----
interface ivmp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] effect;
  logic        [31:0] variance;
  logic               last_cohort;
  modport source (output valid, effect, variance, last_cohort, input ready);
  modport sink (input valid, effect, variance, last_cohort, output ready);
endinterface

interface ivmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pooled_effect;
  logic        [31:0] pooled_variance;
  logic        [31:0] abs_z;
  logic               error;
  modport source (output valid, pooled_effect, pooled_variance, abs_z, error,
                  input ready);
  modport sink (input valid, pooled_effect, pooled_variance, abs_z, error,
                output ready);
endinterface

// ----- rtl/ivmp_ctrl.sv -----
`include "inverse_variance_meta_pool_core_macros.svh"
module ivmp_ctrl import ivmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd = '0;
    cmd.div_sel = DSEL_W;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIVW;
          phase_nxt = 3'd0;
        end
      end
      ST_DIVW: begin
        if (phase_r == 3'd0) begin
          if (sts.vzero) begin
            state_nxt = ST_ACC;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DSEL_W;
            phase_nxt = 3'd1;
          end
        end else if (sts.div_done) begin
          state_nxt = ST_DIVT;
          phase_nxt = 3'd0;
        end
      end
      ST_DIVT: begin
        cmd.div_sel = DSEL_T;
        if (phase_r == 3'd0) begin
          cmd.div_start = 1'b1;
          phase_nxt = 3'd1;
        end else if (sts.div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        phase_nxt = 3'd0;
        if (!sts.last) state_nxt = ST_IDLE;
        else if (sts.wzero) state_nxt = ST_OUT;
        else state_nxt = ST_FIN;
      end
      ST_FIN: begin
        case (phase_r)
          3'd0: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DSEL_PEFF;
            phase_nxt = 3'd1;
          end
          3'd1: begin
            cmd.div_sel = DSEL_PEFF;
            if (sts.div_done) phase_nxt = 3'd2;
          end
          3'd2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DSEL_PVAR;
            phase_nxt = 3'd3;
          end
          3'd3: begin
            cmd.div_sel = DSEL_PVAR;
            if (sts.div_done) phase_nxt = 3'd4;
          end
          3'd4: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DSEL_Z;
            phase_nxt = 3'd5;
          end
          default: begin
            cmd.div_sel = DSEL_Z;
            if (sts.div_done) begin
              state_nxt = ST_ROOT;
              phase_nxt = 3'd0;
            end
          end
        endcase
      end
      ST_ROOT: begin
        if (phase_r == 3'd0) begin
          cmd.sq_start = 1'b1;
          phase_nxt = 3'd1;
        end else if (sts.sq_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  `IVMP_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `IVMP_ASSERT_IMP(a_outclr, clk, rst_n, cmd.out_load, cmd.clear && state_r == ST_OUT)
  `IVMP_ASSERT_NXT(a_load, clk, rst_n, cmd.load, state_r == ST_DIVW)
endmodule

// ----- rtl/ivmp_dp.sv -----
`include "inverse_variance_meta_pool_core_macros.svh"
module ivmp_dp import ivmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic signed [31:0] in_effect,
  input  logic        [31:0] in_variance,
  input  logic               in_last,
  output logic signed [31:0] res_effect,
  output logic        [31:0] res_variance,
  output logic        [31:0] res_z,
  output logic               res_error
);
  logic [31:0] emag_r, var_r;
  logic        eneg_r, last_r;
  logic [63:0] wsum_r, tsum_r;
  logic        zseen_r;
  logic [63:0] w_r, t_r;
  logic [63:0] tmag;
  logic        tneg;

  // Squaring |T| over four 32 by 32 partial products during the pooled-effect divide.
  logic [127:0] sq_r;
  logic [1:0]   pp_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;

  // Shared restoring divider: 192-bit numerator, 64-bit divisor.
  logic [191:0] num_r;
  logic [63:0]  den_r, rem_r, q_r;
  logic [CntW-1:0] cnt_r;
  logic         dbusy_r, qsat_r, ddone;
  logic [191:0] num_sel;
  logic [63:0]  den_sel;
  logic [64:0]  rsh, rdiff;
  logic         qb;

  // Digit-by-digit square root, two radicand bits per step.
  logic [63:0] sx_r, sres_r, sbit_r;
  logic        sbusy_r, sdone;
  logic [63:0] strial;

  logic [31:0] peff_r, pvar_r;

  assign tneg = tsum_r[63];
  assign tmag = tneg ? (64'd0 - tsum_r) : tsum_r;

  always_comb begin
    case (cmd.div_sel)
      DSEL_W: begin
        num_sel = {128'd0, 64'h0100_0000_0000_0000};
        den_sel = {32'd0, var_r};
      end
      DSEL_T: begin
        num_sel = {128'd0, 8'd0, emag_r, 24'd0};
        den_sel = {32'd0, var_r};
      end
      DSEL_PEFF: begin
        num_sel = {64'd0, tmag, 64'd0} >> 32;
        den_sel = wsum_r;
      end
      DSEL_PVAR: begin
        num_sel = {128'd0, 64'h0100_0000_0000_0000};
        den_sel = wsum_r;
      end
      DSEL_Z: begin
        num_sel = {40'd0, sq_r, 24'd0};
        den_sel = wsum_r;
      end
      default: begin
        num_sel = '0;
        den_sel = wsum_r;
      end
    endcase
  end

  assign rsh   = {rem_r, num_r[191]};
  assign rdiff = rsh - {1'b0, den_r};
  assign qb    = !rdiff[64];
  assign ddone = dbusy_r && (cnt_r == CntW'(NumBits - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (ddone) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r  <= num_sel;
      den_r  <= den_sel;
      rem_r  <= '0;
      q_r    <= '0;
      qsat_r <= 1'b0;
      cnt_r  <= '0;
    end else if (dbusy_r) begin
      num_r <= num_r << 1;
      rem_r <= qb ? rdiff[63:0] : rsh[63:0];
      if (q_r[63]) qsat_r <= 1'b1;
      q_r   <= {q_r[62:0], qb};
      cnt_r <= cnt_r + CntW'(1);
    end
  end

  logic [63:0] qfin;
  assign qfin = (qsat_r || q_r[63]) ? 64'hFFFF_FFFF_FFFF_FFFF : {q_r[62:0], qb};

  assign pa = pp_r[0] ? tmag[63:32] : tmag[31:0];
  assign pb = pp_r[1] ? tmag[63:32] : tmag[31:0];
  assign pp = pa * pb;

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DSEL_PEFF) begin
      sq_r <= '0;
      pp_r <= 2'd0;
    end else if (dbusy_r && cmd.div_sel == DSEL_PEFF && cnt_r < CntW'(4)) begin
      sq_r <= sq_r + ({64'd0, pp} << (32 * (pp_r[0] + pp_r[1])));
      pp_r <= pp_r + 2'd1;
    end
  end

  assign strial = sres_r + sbit_r;
  assign sdone  = sbusy_r && (sbit_r[1:0] != 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sq_start) begin
      sbusy_r <= 1'b1;
    end else if (sdone) begin
      sbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ddone && cmd.div_sel == DSEL_Z) begin
      sx_r <= qfin;
    end else if (cmd.sq_start) begin
      sres_r <= '0;
      sbit_r <= 64'h4000_0000_0000_0000;
    end else if (sbusy_r && !sdone) begin
      if (sx_r >= strial) begin
        sx_r   <= sx_r - strial;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end else if (sbusy_r) begin
      if (sx_r >= strial) sres_r <= (sres_r >> 1) + sbit_r;
      else sres_r <= sres_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eneg_r <= in_effect[31];
      emag_r <= in_effect[31] ? (32'd0 - in_effect) : in_effect;
      var_r  <= in_variance;
      last_r <= in_last;
    end
    if (ddone) begin
      case (cmd.div_sel)
        DSEL_W: w_r <= qfin;
        DSEL_T: t_r <= qfin;
        DSEL_PEFF: begin
          if (tneg) peff_r <= (qfin > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - qfin);
          else peff_r <= (qfin > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qfin[31:0];
        end
        DSEL_PVAR: pvar_r <= (qfin > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : qfin[31:0];
        default: w_r <= w_r;
      endcase
    end
  end

  logic [64:0] wadd;
  logic [63:0] tadd;
  assign wadd = {1'b0, wsum_r} + {1'b0, w_r};
  assign tadd = eneg_r ? (tsum_r - t_r) : (tsum_r + t_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      wsum_r  <= '0;
      tsum_r  <= '0;
      zseen_r <= 1'b0;
    end else if (cmd.acc) begin
      if (var_r == 32'd0) begin
        zseen_r <= 1'b1;
      end else begin
        wsum_r <= wadd[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wadd[63:0];
        if (!eneg_r && !tsum_r[63] && tadd[63]) tsum_r <= 64'h7FFF_FFFF_FFFF_FFFF;
        else if (eneg_r && tsum_r[63] && !tadd[63]) tsum_r <= 64'h8000_0000_0000_0000;
        else if (t_r[63] && eneg_r) tsum_r <= 64'h8000_0000_0000_0000;
        else if (t_r[63]) tsum_r <= 64'h7FFF_FFFF_FFFF_FFFF;
        else tsum_r <= tadd;
      end
    end
  end

  logic wz;
  assign wz = (wsum_r == 64'd0);
  assign res_effect   = wz ? 32'sd0 : $signed(peff_r);
  assign res_variance = wz ? 32'hFFFF_FFFF : pvar_r;
  assign res_z        = wz ? 32'd0 : ((sres_r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sres_r[31:0]);
  assign res_error    = zseen_r;

  logic [64:0] wadd_n;
  assign wadd_n = (var_r == 32'd0) ? {1'b0, wsum_r} : wadd;

  assign sts.div_done = ddone;
  assign sts.sq_done  = sdone;
  assign sts.vzero    = (var_r == 32'd0);
  assign sts.wzero    = (wadd_n[64] == 1'b0) && (wadd_n[63:0] == 64'd0);
  assign sts.last     = last_r;

  `IVMP_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(dbusy_r && sbusy_r))
  `IVMP_ASSERT_IMP(a_dstart, clk, rst_n, cmd.div_start, !dbusy_r)
  `IVMP_ASSERT_NXT(a_clear, clk, rst_n, cmd.clear, wsum_r == 64'd0 && !zseen_r)
endmodule

// ----- rtl/inverse_variance_meta_pool_core.sv -----
// Inverse-variance meta-analysis pool. Each input beat is one cohort's
// effect and variance; a beat with last_cohort set yields one output beat
// holding pooled effect, pooled variance, |z| and the zero-variance flag,
// after which the sums clear. One beat is taken at a time: a plain cohort
// takes two passes of the 192-step shared divider (none at zero variance),
// a last one three more and a 32-step square root (none at zero weight sum).
// The output register lets the next beat be accepted while a result waits.
module inverse_variance_meta_pool_core import ivmp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ivmp_in_if.sink   in_ch,
  ivmp_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] r_eff;
  logic [31:0] r_var, r_z;
  logic r_err;
  logic ovalid_r;
  logic signed [31:0] oeff_r;
  logic [31:0] ovar_r, oz_r;
  logic oerr_r;

  ivmp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(ovalid_r && !out_ch.ready), .sts(sts), .cmd(cmd)
  );

  ivmp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_effect(in_ch.effect), .in_variance(in_ch.variance),
    .in_last(in_ch.last_cohort), .res_effect(r_eff), .res_variance(r_var),
    .res_z(r_z), .res_error(r_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oeff_r <= r_eff;
      ovar_r <= r_var;
      oz_r   <= r_z;
      oerr_r <= r_err;
    end
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.pooled_effect   = oeff_r;
  assign out_ch.pooled_variance = ovar_r;
  assign out_ch.abs_z           = oz_r;
  assign out_ch.error           = oerr_r;
endmodule
